// File: rtl/rmm_pkg.sv
// Shared types and defaults for the running min/max/mean block.
package rmm_pkg;

  localparam int SAMPLE_W  = 32;   // sample and min/max field width
  localparam int SUM_W     = 48;   // running sum and mean field width
  localparam int CNT_W     = 17;   // sample count field width

  localparam int MAX_ITEMS_DEF    = 65536;
  localparam int SAMPLE_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF    = 16;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       is_last;
  } rmm_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] min_value;
    logic signed [SAMPLE_W-1:0] max_value;
    logic signed [SUM_W-1:0]    mean_q16;
    logic [CNT_W-1:0]           sample_count;
    logic                       overflow;
  } rmm_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rmm_div_status_t;

endpackage

// File: rtl/rmm_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module rmm_div #(
  parameter int DIV_W = 64,
  parameter int DSR_W = 17
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [DIV_W-1:0]            dividend,
  input  logic [DSR_W-1:0]            divisor,
  output logic [DIV_W-1:0]            quotient,
  output rmm_pkg::rmm_div_status_t    status
);
  import rmm_pkg::*;

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] q_r, q_nxt;
  logic [DSR_W-1:0] rem_r, rem_nxt;
  logic [DSR_W-1:0] dsr_r;
  logic [STEP_W-1:0] step_r;
  logic busy_r, done_r;

  logic [DSR_W:0] rem_sh;
  logic [DSR_W:0] diff;
  logic           fits;

  // shift in the next dividend bit, subtract when the divisor fits
  always_comb begin
    rem_sh  = {rem_r, q_r[DIV_W-1]};
    diff    = rem_sh - {1'b0, dsr_r};
    fits    = (rem_sh >= {1'b0, dsr_r});
    rem_nxt = fits ? diff[DSR_W-1:0] : rem_sh[DSR_W-1:0];
    q_nxt   = {q_r[DIV_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      q_r    <= dividend;
      rem_r  <= '0;
      dsr_r  <= divisor;
      step_r <= STEP_W'(DIV_W);
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      q_r    <= q_nxt;
      rem_r  <= rem_nxt;
      step_r <= step_r - STEP_W'(1);
      if (step_r == STEP_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign quotient    = q_r;
  assign status.busy = busy_r;
  assign status.done = done_r;

endmodule

// File: rtl/running_min_max_mean.sv
// Top level: running minimum, maximum, count and fixed-point mean over sample sets.
//
//  channel | ports                           | carries
//  --------+---------------------------------+------------------------------------
//  input   | in_valid, in_ready, in_data     | sample, is_last
//  result  | out_valid, out_ready, out_data  | min, max, mean_q16, count, overflow
//
// Samples that are not the last of their set are taken back to back while in_ready is high.
// After the last sample, in_ready stays low through S_START and S_DIV, while the
// bit-serial divider forms the mean.
// The result sits in an output register; the next set may start while it waits.
// If the previous result is still not taken when the division ends, the block holds.
// Reset (synchronous) empties the set and drops out_valid.
module running_min_max_mean #(
  parameter int MAX_ITEMS    = rmm_pkg::MAX_ITEMS_DEF,
  parameter int SAMPLE_WIDTH = rmm_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = rmm_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rmm_pkg::rmm_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rmm_pkg::rmm_out_t out_data
);
  import rmm_pkg::*;

  localparam int DIV_W = SUM_W + FRAC_BITS;
  localparam int EXT   = SAMPLE_W - SAMPLE_WIDTH;

  typedef enum logic [1:0] {S_ACC, S_START, S_DIV} state_t;

  state_t state_r;

  logic signed [SAMPLE_W-1:0] min_r, min_nxt;
  logic signed [SAMPLE_W-1:0] max_r, max_nxt;
  logic signed [SUM_W-1:0]    sum_r, sum_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       ovf_r, ovf_nxt;
  logic                       neg_r;
  logic                       out_valid_r;
  rmm_out_t                   out_r;

  logic signed [SAMPLE_W-1:0] s_shl;
  logic signed [SAMPLE_W-1:0] s_ext;
  logic                       in_acc;
  logic                       load;
  logic                       div_start;
  logic [SUM_W-1:0]           mag;
  logic [DIV_W-1:0]           div_quot;
  logic [SUM_W-1:0]           q_low;
  rmm_div_status_t            div_stat;

  // keep only the low SAMPLE_WIDTH bits, sign extended
  always_comb begin
    s_shl = in_data.sample <<< EXT;
    s_ext = s_shl >>> EXT;
  end

  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    sum_nxt = sum_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    if (cnt_r == '0) begin
      min_nxt = s_ext;
      max_nxt = s_ext;
      sum_nxt = SUM_W'(s_ext);
      cnt_nxt = CNT_W'(1);
      ovf_nxt = 1'b0;
    end else begin
      if (s_ext < min_r) min_nxt = s_ext;
      if (s_ext > max_r) max_nxt = s_ext;
      if (cnt_r < CNT_W'(MAX_ITEMS)) begin
        sum_nxt = sum_r + SUM_W'(s_ext);
        cnt_nxt = cnt_r + CNT_W'(1);
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  assign in_ready  = (state_r == S_ACC);
  assign in_acc    = in_valid && in_ready;
  assign div_start = (state_r == S_START);
  assign load      = (state_r == S_DIV) && div_stat.done && (!out_valid_r || out_ready);
  assign mag       = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign q_low     = div_quot[SUM_W-1:0];

  rmm_div #(
    .DIV_W (DIV_W),
    .DSR_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (DIV_W'(mag) << FRAC_BITS),
    .divisor  (cnt_r),
    .quotient (div_quot),
    .status   (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_ACC;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_ACC: begin
          if (in_acc) begin
            min_r <= min_nxt;
            max_r <= max_nxt;
            sum_r <= sum_nxt;
            cnt_r <= cnt_nxt;
            ovf_r <= ovf_nxt;
            if (in_data.is_last) state_r <= S_START;
          end
        end
        S_START: begin
          neg_r   <= sum_r[SUM_W-1];
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (load) begin
            out_r.min_value    <= min_r;
            out_r.max_value    <= max_r;
            out_r.mean_q16     <= neg_r ? -q_low : q_low;
            out_r.sample_count <= cnt_r;
            out_r.overflow     <= ovf_r;
            cnt_r              <= '0;
            ovf_r              <= 1'b0;
            state_r            <= S_ACC;
          end
        end
        default: state_r <= S_ACC;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // a result only appears at the end of a division
  a_result_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_DIV) && $past(div_stat.done))
    else $error("result raised outside the division end");

  // the last sample of a set closes the input until the mean is formed
  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.is_last) |=> !in_ready)
    else $error("input open after last sample");

  // no sample is taken while the divider runs
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> !in_ready)
    else $error("input open while dividing");

  // a delivered set is never empty, and overflow means a saturated count
  a_count_sane: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.sample_count != '0) &&
                  (!out_data.overflow || out_data.sample_count == CNT_W'(MAX_ITEMS)))
    else $error("bad count in result");

endmodule
